FILE: rtl/mrpm_pkg.sv
// ----------------------------------------------------------------------------
// mrpm_pkg
// shared types and constants for the memory region permission map
// ----------------------------------------------------------------------------
package mrpm_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned LimitW = 33;
  localparam int unsigned PermInW = 3;
  localparam int unsigned PagesW = 33;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [2:0] {
    FN_MAP_OR     = 3'd0,
    FN_UNMAP      = 3'd1,
    FN_PROTECT    = 3'd2,
    FN_ACCESSIBLE = 3'd3,
    FN_OVERLAPS   = 3'd4,
    FN_PAGE_SUM   = 3'd5
  } func_e;

  // divider handshake
  typedef struct packed {
    logic              start;
    logic [LimitW-1:0] dividend;
    logic [AddrW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PagesW-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: rtl/mrpm_ram.sv
// ----------------------------------------------------------------------------
// mrpm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mrpm_ram #(
  parameter int unsigned WIDTH = 68,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/mrpm_div.sv
// ----------------------------------------------------------------------------
// mrpm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mrpm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mrpm_pkg::div_req_t        req_i,
  output mrpm_pkg::div_rsp_t        rsp_o
);
  import mrpm_pkg::*;

  logic [LimitW-1:0] num_q, num_d;
  logic [AddrW-1:0]  rem_q, rem_d;
  logic [AddrW-1:0]  dsr_q, dsr_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [AddrW:0]    trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[LimitW-1]};
    if (req_i.start) begin
      num_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = 6'(LimitW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = AddrW'(trial - {1'b0, dsr_q});
        num_d = {num_q[LimitW-2:0], 1'b1};
      end else begin
        rem_d = trial[AddrW-1:0];
        num_d = {num_q[LimitW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = num_q;

endmodule

FILE: rtl/memory_region_permission_map_core.sv
// ----------------------------------------------------------------------------
// memory_region_permission_map_core
// sorted, coalesced table of address regions with permission bits
// ----------------------------------------------------------------------------
// The table lives in two ram banks. One holds the live table; a change
// (map_or, unmap, protect) walks the live bank region by region, builds the
// new coalesced table in the other bank and swaps banks only if the result
// fits in MAX_REGIONS entries, so a rejected change leaves the table as it
// was. One beat is taken at a time and the block is busy until its answer
// is in the output register. Steps per beat: map_or and unmap read, load
// and emit in four steps for each region; protect first walks the regions
// to check coverage, then rebuilds; accessible and overlaps read, load and
// check each region until the answer is known; the page sum reads and
// loads each region, starts the shared one-bit-per-cycle divider on it
// and waits for its quotient. Invalid ranges, a zero granule and unused
// selectors skip the walk and go straight to the answer.
module memory_region_permission_map_core #(
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned PERM_BITS   = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_req[31:0], end_addr[64:32], perms[67:65], granule[99:68], zero
  input  logic [mrpm_pkg::InDataW-1:0]  s_axis_tdata,
  // func[2:0]
  input  logic [2:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ok[0], table_full[1], pages[34:2], zero
  output logic [mrpm_pkg::OutDataW-1:0] m_axis_tdata
);
  import mrpm_pkg::*;

  localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned SW = $clog2(2 * MAX_REGIONS + 5);
  localparam int unsigned DW = AddrW + LimitW + PERM_BITS;

  // one-hot sequencer
  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_RD     = 10'b00_0000_0010,
    S_LD     = 10'b00_0000_0100,
    S_EMIT   = 10'b00_0000_1000,
    S_CHK    = 10'b00_0001_0000,
    S_DIV    = 10'b00_0010_0000,
    S_END    = 10'b00_0100_0000,
    S_FLUSH  = 10'b00_1000_0000,
    S_COMMIT = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // captured beat
  logic [2:0]           fn_q, fn_d;
  logic [AddrW-1:0]     s_q, s_d;
  logic [LimitW-1:0]    e_q, e_d;
  logic [PERM_BITS-1:0] p_q, p_d;
  logic [AddrW-1:0]     ps_q, ps_d;
  logic                 rebuild_q, rebuild_d;   // walk builds a new table

  // live table
  logic          bank_q, bank_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // walk state
  logic [CW-1:0]        idx_q, idx_d;
  logic [1:0]           k_q, k_d;
  logic [LimitW-1:0]    cur_q, cur_d;
  logic [AddrW-1:0]     rb_q, rb_d;
  logic [LimitW-1:0]    rl_q, rl_d;
  logic [PERM_BITS-1:0] rr_q, rr_d;

  // pending scratch entry, merged with the next emit when they touch and carry the same rights
  logic                 pv_q, pv_d;
  logic [AddrW-1:0]     pb_q, pb_d;
  logic [LimitW-1:0]    pl_q, pl_d;
  logic [PERM_BITS-1:0] pr_q, pr_d;
  logic [SW-1:0]        wcnt_q, wcnt_d;

  // answer
  logic              ok_q, ok_d;
  logic              full_q, full_d;
  logic [PagesW-1:0] sum_q, sum_d;
  logic              ov_q, ov_d;
  logic [OutDataW-1:0] out_q, out_d;

  // ram ports
  logic          wr_pend;
  logic          we0, we1;
  logic [DW-1:0] rd0, rd1, rdata, wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // input field views
  logic [AddrW-1:0]     in_s, in_ps;
  logic [LimitW-1:0]    in_e;
  logic [PermInW-1:0]   in_p;
  logic [PERM_BITS-1:0] in_pm;

  assign in_s  = s_axis_tdata[31:0];
  assign in_e  = s_axis_tdata[64:32];
  assign in_p  = s_axis_tdata[67:65];
  assign in_ps = s_axis_tdata[99:68];

  // permissions masked to PERM_BITS
  always_comb begin
    in_pm = '0;
    for (int i = 0; i < PERM_BITS; i++) begin
      if (i < PermInW) begin
        in_pm[i] = in_p[i];
      end
    end
  end

  // region classification
  logic [LimitW-1:0] s_x, b_x, ms, me;
  logic              case_a, case_b;
  assign s_x    = {1'b0, s_q};
  assign b_x    = {1'b0, rb_q};
  assign case_a = rl_q <= s_x;
  assign case_b = !case_a && (b_x >= e_q);
  assign ms     = (b_x > s_x) ? b_x : s_x;
  assign me     = (rl_q < e_q) ? rl_q : e_q;

  // emit candidate
  logic                 c_v;
  logic [LimitW-1:0]    c_b, c_l;
  logic [PERM_BITS-1:0] c_r;
  logic                 mode_map, mode_prot;
  assign mode_map  = fn_q == FN_MAP_OR;
  assign mode_prot = fn_q == FN_PROTECT;

  always_comb begin
    c_v = 1'b0;
    c_b = b_x;
    c_l = rl_q;
    c_r = rr_q;
    if (state_q == S_END) begin
      c_v = mode_map;
      c_b = cur_q;
      c_l = e_q;
      c_r = p_q;
    end else begin
      case (k_q)
        2'd0: begin
          if (case_a) begin
            c_v = 1'b1;
          end else if (case_b) begin
            c_v = mode_map;
            c_b = cur_q;
            c_l = e_q;
            c_r = p_q;
          end else begin
            c_v = 1'b1;
            c_l = s_x;
          end
        end
        2'd1: begin
          if (case_b) begin
            c_v = 1'b1;
          end else if (!case_a) begin
            c_v = mode_map;
            c_b = cur_q;
            c_l = ms;
            c_r = p_q;
          end
        end
        2'd2: begin
          c_v = !case_a && !case_b && (mode_map || mode_prot);
          c_b = ms;
          c_l = me;
          c_r = mode_map ? (rr_q | p_q) : p_q;
        end
        default: begin
          c_v = !case_a && !case_b;
          c_b = e_q;
        end
      endcase
    end
  end

  // walk helpers
  logic          last_rgn;
  logic          rights_ok;
  logic [PERM_BITS-1:0] need;
  assign last_rgn  = (idx_q + CW'(1)) == cnt_q;
  assign need      = (fn_q == FN_ACCESSIBLE) ? p_q : '0;
  assign rights_ok = (rr_q & need) == need;

  logic in_valid;
  assign in_valid = (in_e > {1'b0, in_s}) && (in_e <= {1'b1, {AddrW{1'b0}}});

  always_comb begin
    state_d   = state_q;
    fn_d      = fn_q;
    s_d       = s_q;
    e_d       = e_q;
    p_d       = p_q;
    ps_d      = ps_q;
    rebuild_d = rebuild_q;
    bank_d    = bank_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    k_d       = k_q;
    cur_d     = cur_q;
    rb_d      = rb_q;
    rl_d      = rl_q;
    rr_d      = rr_q;
    pv_d      = pv_q;
    pb_d      = pb_q;
    pl_d      = pl_q;
    pr_d      = pr_q;
    wcnt_d    = wcnt_q;
    ok_d      = ok_q;
    full_d    = full_q;
    sum_d     = sum_q;
    ov_d      = ov_q;
    out_d     = out_q;
    wr_pend   = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rl_q - b_x;
    div_req.divisor  = ps_q;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          fn_d   = s_axis_tuser;
          s_d    = in_s;
          e_d    = in_e;
          p_d    = in_pm;
          ps_d   = in_ps;
          ok_d   = 1'b0;
          full_d = 1'b0;
          sum_d  = '0;
          idx_d  = '0;
          k_d    = '0;
          cur_d  = {1'b0, in_s};
          pv_d   = 1'b0;
          wcnt_d = '0;
          rebuild_d = (s_axis_tuser == FN_MAP_OR) || (s_axis_tuser == FN_UNMAP);
          if (s_axis_tuser > FN_PAGE_SUM) begin
            state_d = S_DONE;
          end else if (s_axis_tuser != FN_PAGE_SUM && !in_valid) begin
            state_d = S_DONE;
          end else if (s_axis_tuser == FN_PAGE_SUM && in_ps == '0) begin
            state_d = S_DONE;
          end else if (cnt_q == '0) begin
            state_d = S_END;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_LD;
      end
      S_LD: begin
        rb_d = rdata[AddrW-1:0];
        rl_d = rdata[AddrW +: LimitW];
        rr_d = rdata[AddrW+LimitW +: PERM_BITS];
        k_d  = '0;
        if (rebuild_q) begin
          state_d = S_EMIT;
        end else if (fn_q == FN_PAGE_SUM) begin
          state_d = S_DIV;
        end else begin
          state_d = S_CHK;
        end
      end
      S_EMIT: begin
        if (k_q == 2'd0 && case_b) begin
          cur_d = e_q;
        end
        if (k_q == 2'd2 && !case_a && !case_b) begin
          cur_d = me;
        end
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          idx_d   = idx_q + CW'(1);
          state_d = last_rgn ? S_END : S_RD;
        end
      end
      S_CHK: begin
        idx_d   = idx_q + CW'(1);
        state_d = last_rgn ? S_END : S_RD;
        if (fn_q == FN_OVERLAPS) begin
          if (b_x < e_q && rl_q > s_x) begin
            ok_d    = 1'b1;
            state_d = S_DONE;
          end
        end else if (rl_q > cur_q) begin
          if (b_x > cur_q || !rights_ok) begin
            state_d = S_DONE;
          end else begin
            cur_d = rl_q;
            if (rl_q >= e_q) begin
              if (fn_q == FN_PROTECT) begin
                // range fully mapped, now rebuild with new rights
                rebuild_d = 1'b1;
                idx_d     = '0;
                cur_d     = s_x;
                state_d   = S_RD;
              end else begin
                ok_d    = 1'b1;
                state_d = S_DONE;
              end
            end
          end
        end
      end
      S_DIV: begin
        if (k_q == 2'd0) begin
          div_req.start = 1'b1;
          k_d = 2'd1;
        end else if (div_rsp.done) begin
          sum_d   = sum_q + div_rsp.quotient;
          idx_d   = idx_q + CW'(1);
          state_d = last_rgn ? S_END : S_RD;
        end
      end
      S_END: begin
        if (rebuild_q) begin
          state_d = S_FLUSH;
        end else begin
          ok_d    = fn_q == FN_PAGE_SUM;
          state_d = S_DONE;
        end
      end
      S_FLUSH: begin
        if (pv_q) begin
          wr_pend = 1'b1;
          wcnt_d  = wcnt_q + SW'(1);
        end
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (wcnt_q <= SW'(MAX_REGIONS)) begin
          bank_d = !bank_q;
          cnt_d  = wcnt_q[CW-1:0];
          ok_d   = 1'b1;
        end else begin
          full_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          out_d   = {5'd0, sum_q, full_q, ok_q};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // scratch emit with coalescing against the pending entry
    if ((state_q == S_EMIT || (state_q == S_END && rebuild_q)) && c_v && c_b < c_l) begin
      if (pv_q && pl_q == c_b && pr_q == c_r) begin
        pl_d = c_l;
      end else begin
        if (pv_q) begin
          wr_pend = 1'b1;
          wcnt_d  = wcnt_q + SW'(1);
        end
        pv_d = 1'b1;
        pb_d = c_b[AddrW-1:0];
        pl_d = c_l;
        pr_d = c_r;
      end
    end
  end

  // banks: read the live one, write the scratch one
  assign wdata = {pr_q, pl_q, pb_q};
  assign we0   = wr_pend && (wcnt_q < SW'(MAX_REGIONS)) && bank_q;
  assign we1   = wr_pend && (wcnt_q < SW'(MAX_REGIONS)) && !bank_q;
  assign rdata = bank_q ? rd1 : rd0;

  mrpm_ram #(.WIDTH(DW), .DEPTH(MAX_REGIONS)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wcnt_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd0)
  );

  mrpm_ram #(.WIDTH(DW), .DEPTH(MAX_REGIONS)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wcnt_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rd1)
  );

  // shared divider for the page sum
  mrpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bank_q    <= 1'b0;
      cnt_q     <= '0;
      ov_q      <= 1'b0;
      rebuild_q <= 1'b0;
      idx_q     <= '0;
      k_q       <= '0;
      pv_q      <= 1'b0;
      wcnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      bank_q    <= bank_d;
      cnt_q     <= cnt_d;
      ov_q      <= ov_d;
      rebuild_q <= rebuild_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      pv_q      <= pv_d;
      wcnt_q    <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fn_q   <= fn_d;
    s_q    <= s_d;
    e_q    <= e_d;
    p_q    <= p_d;
    ps_q   <= ps_d;
    cur_q  <= cur_d;
    rb_q   <= rb_d;
    rl_q   <= rl_d;
    rr_q   <= rr_d;
    pb_q   <= pb_d;
    pl_q   <= pl_d;
    pr_q   <= pr_d;
    ok_q   <= ok_d;
    full_q <= full_d;
    sum_q  <= sum_d;
    out_q  <= out_d;
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

endmodule
